[rtl/core/chmb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmb_pkg
// Shared types and constants for the convex hull / minimum breadth block.
// ----------------------------------------------------------------------------
package chmb_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int BREADTH_BITS   = 29;

	// shift applied to a product before it enters the accumulator
	typedef enum logic [1:0] {
		SH_NONE,
		SH_LO,
		SH_MID,
		SH_HI
	} mac_sh_t;

	typedef struct packed {
		logic    en;
		logic    clr;
		logic    sub;
		mac_sh_t sh;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		RT_IDLE,
		RT_DIV,
		RT_PREP,
		RT_SQRT,
		RT_DONE
	} root_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} root_stat_t;

	typedef enum logic [5:0] {
		S_LOAD,
		S_SORT_I,
		S_SORT_V,
		S_SORT_CMP,
		S_SORT_PUT,
		S_SEL,
		S_COPY_RD,
		S_COPY_WR,
		S_CH_RD,
		S_CH_GET,
		S_UP_TEST,
		S_UP_O,
		S_UP_A,
		S_UP_C1,
		S_UP_C2,
		S_UP_DEC,
		S_UP_PUSH,
		S_DN_TEST,
		S_DN_O,
		S_DN_A,
		S_DN_C1,
		S_DN_C2,
		S_DN_DEC,
		S_DN_PUSH,
		S_MRG_RD,
		S_MRG_WR,
		S_B_EDGE,
		S_B_RB,
		S_B_LB,
		S_B_L1,
		S_B_L2,
		S_B_LCHK,
		S_B_RK,
		S_B_K,
		S_B_C1,
		S_B_C2,
		S_B_CMAX,
		S_B_SQ1,
		S_B_SQ2,
		S_B_SQ3,
		S_B_ROOT,
		S_B_WAIT,
		S_E_RD,
		S_E_WAIT
	} seq_state_t;

endpackage

[rtl/core/chmb_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmb_mac
// Shared signed multiply-accumulate unit: one product per cycle while ctl.en
// is set, shifted and added to or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
module chmb_mac #(
	parameter int COORD_BITS = chmb_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = chmb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  chmb_pkg::mac_ctl_t                    ctl,
	input  logic signed [COORD_BITS+1:0]          ma,
	input  logic signed [COORD_BITS+1:0]          mb,
	output logic signed [4*COORD_BITS+4+2*FRAC_BITS:0] acc
);
	import chmb_pkg::*;

	localparam int MW  = COORD_BITS + 2;
	localparam int H   = COORD_BITS + 1;
	localparam int CMW = 2 * H;
	localparam int ACW = 2 * CMW + 2 * FRAC_BITS + 1;

	logic signed [2*MW-1:0] prod;
	logic signed [ACW-1:0]  term;
	logic signed [ACW-1:0]  base;
	logic signed [ACW-1:0]  acc_q;

	assign prod = ma * mb;

	always_comb begin
		case (ctl.sh)
			SH_LO:   term = ACW'(prod) <<< (2 * FRAC_BITS);
			SH_MID:  term = ACW'(prod) <<< (H + 1 + 2 * FRAC_BITS);
			SH_HI:   term = ACW'(prod) <<< (2 * H + 2 * FRAC_BITS);
			default: term = ACW'(prod);
		endcase
		base = ctl.clr ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= ctl.sub ? (base - term) : (base + term);
		end
	end

	assign acc = acc_q;

endmodule

[rtl/core/chmb_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmb_root
// Iterative floor(sqrt(dividend / divisor)): restoring divide one bit per
// cycle, then a digit-by-digit square root, saturated to the breadth width.
// ----------------------------------------------------------------------------
module chmb_root #(
	parameter int COORD_BITS = chmb_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = chmb_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [4*COORD_BITS+3+2*FRAC_BITS:0]      dividend,
	input  logic [2*COORD_BITS:0]                    divisor,
	output chmb_pkg::root_stat_t                     stat,
	output logic [chmb_pkg::BREADTH_BITS-1:0]        root
);
	import chmb_pkg::*;

	localparam int BW  = BREADTH_BITS;
	localparam int LW  = 2 * COORD_BITS + 1;
	localparam int CQW = 4 * COORD_BITS + 4 + 2 * FRAC_BITS;
	localparam int DQW = (CQW > 2 * BW) ? CQW : 2 * BW;
	localparam int CTW = $clog2(DQW + 1);

	root_state_t       state_q, state_d;
	logic [DQW-1:0]    num_q, num_d;
	logic [LW-1:0]     div_q, div_d;
	logic [LW-1:0]     rem_q, rem_d;
	logic [2*BW-1:0]   rad_q, rad_d;
	logic [BW+1:0]     srem_q, srem_d;
	logic [BW-1:0]     res_q, res_d;
	logic              sat_q, sat_d;
	logic [CTW-1:0]    cnt_q, cnt_d;
	logic [LW:0]       t_div, d_div;
	logic [BW+3:0]     t_sq, trial, d_sq;
	logic              ge_div, ge_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		num_q  <= num_d;
		div_q  <= div_d;
		rem_q  <= rem_d;
		rad_q  <= rad_d;
		srem_q <= srem_d;
		res_q  <= res_d;
		sat_q  <= sat_d;
		cnt_q  <= cnt_d;
	end

	always_comb begin
		state_d = state_q;
		num_d   = num_q;
		div_d   = div_q;
		rem_d   = rem_q;
		rad_d   = rad_q;
		srem_d  = srem_q;
		res_d   = res_q;
		sat_d   = sat_q;
		cnt_d   = cnt_q;
		t_div   = {rem_q, num_q[DQW-1]};
		d_div   = t_div - {1'b0, div_q};
		ge_div  = t_div >= {1'b0, div_q};
		t_sq    = {srem_q, rad_q[2*BW-1 -: 2]};
		trial   = (BW + 4)'({res_q, 2'b01});
		d_sq    = t_sq - trial;
		ge_sq   = t_sq >= trial;
		stat.busy = (state_q != RT_IDLE);
		stat.done = 1'b0;
		case (state_q)
			RT_IDLE: begin
				if (start) begin
					num_d   = DQW'(dividend);
					div_d   = divisor;
					rem_d   = '0;
					cnt_d   = '0;
					state_d = RT_DIV;
				end
			end
			RT_DIV: begin
				rem_d = ge_div ? d_div[LW-1:0] : t_div[LW-1:0];
				num_d = {num_q[DQW-2:0], ge_div};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CTW'(DQW - 1)) begin
					state_d = RT_PREP;
				end
			end
			RT_PREP: begin
				sat_d   = (num_q >> (2 * BW)) != '0;
				rad_d   = num_q[2*BW-1:0];
				srem_d  = '0;
				res_d   = '0;
				cnt_d   = '0;
				state_d = RT_SQRT;
			end
			RT_SQRT: begin
				srem_d = ge_sq ? d_sq[BW+1:0] : t_sq[BW+1:0];
				res_d  = {res_q[BW-2:0], ge_sq};
				rad_d  = {rad_q[2*BW-3:0], 2'b00};
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CTW'(BW - 1)) begin
					state_d = RT_DONE;
				end
			end
			RT_DONE: begin
				stat.done = 1'b1;
				state_d   = RT_IDLE;
			end
			default: begin
				state_d = RT_IDLE;
			end
		endcase
	end

	assign root = sat_q ? {BW{1'b1}} : res_q;

endmodule

[rtl/core/convex_hull_min_breadth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_min_breadth
// Convex hull (monotone chain) and minimum breadth of a set of 2-D points.
// ----------------------------------------------------------------------------
// Points enter on the in channel (point_x, point_y, last_point), one
// transaction per cycle while in_ready is high; up to MAX_POINTS are kept,
// later ones are dropped. The transaction with last_point starts the run and
// in_ready stays low until the last hull vertex has been handed to the output
// register. Hull vertices leave on the out channel in clockwise order from
// the lowest sorted point; the final one has last_vertex set and carries
// min_breadth and degenerate. A set of fewer than four points is returned as
// sorted. For n stored points the run takes up to about n*n/2 insertion sort
// steps (one memory read per step), then the chain tests, then per hull edge
// the cross products in the shared multiply-accumulate unit and a pass
// through the divide and square root unit, then the vertices out. A stalled
// receiver holds the output register and the sequencer waits on it. After
// reset the block is empty and ready for points.
// ----------------------------------------------------------------------------
module convex_hull_min_breadth #(
	parameter int MAX_POINTS = chmb_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = chmb_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = chmb_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_BITS-1:0]        hull_x,
	output logic signed [COORD_BITS-1:0]        hull_y,
	output logic                                last_vertex,
	output logic [chmb_pkg::BREADTH_BITS-1:0]   min_breadth,
	output logic                                degenerate
);
	import chmb_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int VW   = 2 * CW;
	localparam int DW   = CW + 1;
	localparam int MW   = CW + 2;
	localparam int H    = CW + 1;
	localparam int CMW  = 2 * H;
	localparam int LW   = 2 * CW + 1;
	localparam int CQW  = 2 * CMW + 2 * FRAC_BITS;
	localparam int ACW  = CQW + 1;
	localparam int BB   = BREADTH_BITS;
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);

	seq_state_t state_q, state_d;

	logic [CNTW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
	logic [CNTW-1:0] up_q, up_d, dn_q, dn_d, hn_q, hn_d;
	logic            found_q, found_d;
	logic [BB-1:0]   best_q, best_d;
	logic [CMW-1:0]  cmax_q, cmax_d;
	logic [LW-1:0]   len2_q, len2_d;
	logic [VW-1:0]   v_q, v_d, o_q, o_d, a_q, a_d, b_q, b_d;

	logic            ov_q, ov_d, olast_q, olast_d, odeg_q, odeg_d;
	logic [VW-1:0]   ovtx_q, ovtx_d;
	logic [BB-1:0]   obr_q, obr_d;

	// point, hull and lower chain memories
	logic [VW-1:0]   pmem [MAX_POINTS];
	logic [VW-1:0]   hmem [MAX_POINTS];
	logic [VW-1:0]   lmem [MAX_POINTS];
	logic            p_we, p_re, h_we, h_re, l_we, l_re;
	logic [AW-1:0]   p_wa, p_ra, h_wa, h_ra, l_wa, l_ra;
	logic [VW-1:0]   p_wd, h_wd, l_wd, p_rd_q, h_rd_q, l_rd_q;

	mac_ctl_t              mac_ctl;
	logic signed [MW-1:0]  ma, mb;
	logic signed [ACW-1:0] acc, acc_neg;
	logic                  root_start;
	root_stat_t            root_stat;
	logic [BB-1:0]         root_val;

	logic [CNTW-1:0] up_m1, up_m2, dn_m1, dn_m2, i_m1, i_p1, j_m1, j_m2, k_p1;
	logic signed [CW-1:0] vx, vy, wx, wy, ox, oy, ax, ay, bx, by;
	logic signed [DW-1:0] d_ax, d_ay, d_bx, d_by;
	logic [ACW-1:0]  mag_full;
	logic [CMW-1:0]  cmag;
	logic            v_before;

	assign up_m1 = up_q - 1'b1;
	assign up_m2 = up_q - CNTW'(2);
	assign dn_m1 = dn_q - 1'b1;
	assign dn_m2 = dn_q - CNTW'(2);
	assign i_m1  = i_q - 1'b1;
	assign i_p1  = i_q + 1'b1;
	assign j_m1  = j_q - 1'b1;
	assign j_m2  = j_q - CNTW'(2);
	assign k_p1  = k_q + 1'b1;

	assign vx = v_q[VW-1:CW];
	assign vy = v_q[CW-1:0];
	assign wx = p_rd_q[VW-1:CW];
	assign wy = p_rd_q[CW-1:0];
	assign ox = o_q[VW-1:CW];
	assign oy = o_q[CW-1:0];
	assign ax = a_q[VW-1:CW];
	assign ay = a_q[CW-1:0];
	assign bx = b_q[VW-1:CW];
	assign by = b_q[CW-1:0];
	assign d_ax = DW'(ax) - DW'(ox);
	assign d_ay = DW'(ay) - DW'(oy);
	assign d_bx = DW'(bx) - DW'(ox);
	assign d_by = DW'(by) - DW'(oy);

	assign v_before = (vx < wx) || ((vx == wx) && (vy < wy));
	assign acc_neg  = -acc;
	assign mag_full = acc[ACW-1] ? acc_neg : acc;
	assign cmag     = mag_full[CMW-1:0];

	chmb_mac #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk(clk),
		.ctl(mac_ctl),
		.ma (ma),
		.mb (mb),
		.acc(acc)
	);

	chmb_root #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.dividend(acc[CQW-1:0]),
		.divisor (len2_q),
		.stat    (root_stat),
		.root    (root_val)
	);

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		if (p_re) begin
			p_rd_q <= pmem[p_ra];
		end
		if (h_we) begin
			hmem[h_wa] <= h_wd;
		end
		if (h_re) begin
			h_rd_q <= hmem[h_ra];
		end
		if (l_we) begin
			lmem[l_wa] <= l_wd;
		end
		if (l_re) begin
			l_rd_q <= lmem[l_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q     <= i_d;
		j_q     <= j_d;
		k_q     <= k_d;
		up_q    <= up_d;
		dn_q    <= dn_d;
		hn_q    <= hn_d;
		found_q <= found_d;
		best_q  <= best_d;
		cmax_q  <= cmax_d;
		len2_q  <= len2_d;
		v_q     <= v_d;
		o_q     <= o_d;
		a_q     <= a_d;
		b_q     <= b_d;
		olast_q <= olast_d;
		odeg_q  <= odeg_d;
		ovtx_q  <= ovtx_d;
		obr_q   <= obr_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		up_d    = up_q;
		dn_d    = dn_q;
		hn_d    = hn_q;
		found_d = found_q;
		best_d  = best_q;
		cmax_d  = cmax_q;
		len2_d  = len2_q;
		v_d     = v_q;
		o_d     = o_q;
		a_d     = a_q;
		b_d     = b_q;
		ov_d    = ov_q && !out_ready;
		olast_d = olast_q;
		odeg_d  = odeg_q;
		ovtx_d  = ovtx_q;
		obr_d   = obr_q;
		p_we = 1'b0; p_wa = '0; p_wd = '0; p_re = 1'b0; p_ra = '0;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_re = 1'b0; h_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_re = 1'b0; l_ra = '0;
		mac_ctl    = '0;
		ma         = '0;
		mb         = '0;
		root_start = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cnt_q < CNTW'(MAX_POINTS)) begin
						p_we  = 1'b1;
						p_wa  = cnt_q[AW-1:0];
						p_wd  = {point_x, point_y};
						cnt_d = cnt_q + 1'b1;
					end
					if (last_point) begin
						i_d     = CNTW'(1);
						state_d = S_SORT_I;
					end
				end
			end
			S_SORT_I: begin
				if (i_q < cnt_q) begin
					p_re    = 1'b1;
					p_ra    = i_q[AW-1:0];
					state_d = S_SORT_V;
				end else begin
					state_d = S_SEL;
				end
			end
			S_SORT_V: begin
				v_d     = p_rd_q;
				j_d     = i_q;
				p_re    = 1'b1;
				p_ra    = i_m1[AW-1:0];
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				p_we = 1'b1;
				p_wa = j_q[AW-1:0];
				if (v_before) begin
					p_wd = p_rd_q;
					j_d  = j_m1;
					if (j_q == CNTW'(1)) begin
						state_d = S_SORT_PUT;
					end else begin
						p_re = 1'b1;
						p_ra = j_m2[AW-1:0];
					end
				end else begin
					p_wd    = v_q;
					i_d     = i_p1;
					state_d = S_SORT_I;
				end
			end
			S_SORT_PUT: begin
				p_we    = 1'b1;
				p_wa    = j_q[AW-1:0];
				p_wd    = v_q;
				i_d     = i_p1;
				state_d = S_SORT_I;
			end
			S_SEL: begin
				i_d  = '0;
				up_d = '0;
				dn_d = '0;
				state_d = (cnt_q <= CNTW'(3)) ? S_COPY_RD : S_CH_RD;
			end
			S_COPY_RD: begin
				if (i_q < cnt_q) begin
					p_re    = 1'b1;
					p_ra    = i_q[AW-1:0];
					state_d = S_COPY_WR;
				end else begin
					hn_d    = cnt_q;
					i_d     = '0;
					found_d = 1'b0;
					best_d  = '0;
					state_d = S_B_EDGE;
				end
			end
			S_COPY_WR: begin
				h_we    = 1'b1;
				h_wa    = i_q[AW-1:0];
				h_wd    = p_rd_q;
				i_d     = i_p1;
				state_d = S_COPY_RD;
			end
			S_CH_RD: begin
				p_re    = 1'b1;
				p_ra    = i_q[AW-1:0];
				state_d = S_CH_GET;
			end
			S_CH_GET: begin
				b_d     = p_rd_q;
				state_d = S_UP_TEST;
			end
			S_UP_TEST: begin
				if (up_q >= CNTW'(2)) begin
					h_re    = 1'b1;
					h_ra    = up_m2[AW-1:0];
					state_d = S_UP_O;
				end else begin
					state_d = S_UP_PUSH;
				end
			end
			S_UP_O: begin
				o_d     = h_rd_q;
				h_re    = 1'b1;
				h_ra    = up_m1[AW-1:0];
				state_d = S_UP_A;
			end
			S_UP_A: begin
				a_d     = h_rd_q;
				state_d = S_UP_C1;
			end
			S_UP_C1, S_DN_C1, S_B_C1: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				ma = MW'(d_ax);
				mb = MW'(d_by);
				case (state_q)
					S_UP_C1: state_d = S_UP_C2;
					S_DN_C1: state_d = S_DN_C2;
					default: state_d = S_B_C2;
				endcase
			end
			S_UP_C2, S_DN_C2, S_B_C2: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.sub = 1'b1;
				ma = MW'(d_ay);
				mb = MW'(d_bx);
				case (state_q)
					S_UP_C2: state_d = S_UP_DEC;
					S_DN_C2: state_d = S_DN_DEC;
					default: state_d = S_B_CMAX;
				endcase
			end
			S_UP_DEC: begin
				// pop on a non-right turn
				if (!acc[ACW-1]) begin
					up_d    = up_m1;
					state_d = S_UP_TEST;
				end else begin
					state_d = S_UP_PUSH;
				end
			end
			S_UP_PUSH: begin
				h_we    = 1'b1;
				h_wa    = up_q[AW-1:0];
				h_wd    = b_q;
				up_d    = up_q + 1'b1;
				state_d = S_DN_TEST;
			end
			S_DN_TEST: begin
				if (dn_q >= CNTW'(2)) begin
					l_re    = 1'b1;
					l_ra    = dn_m2[AW-1:0];
					state_d = S_DN_O;
				end else begin
					state_d = S_DN_PUSH;
				end
			end
			S_DN_O: begin
				o_d     = l_rd_q;
				l_re    = 1'b1;
				l_ra    = dn_m1[AW-1:0];
				state_d = S_DN_A;
			end
			S_DN_A: begin
				a_d     = l_rd_q;
				state_d = S_DN_C1;
			end
			S_DN_DEC: begin
				// pop on a non-left turn
				if (acc[ACW-1] || (acc == '0)) begin
					dn_d    = dn_m1;
					state_d = S_DN_TEST;
				end else begin
					state_d = S_DN_PUSH;
				end
			end
			S_DN_PUSH: begin
				l_we = 1'b1;
				l_wa = dn_q[AW-1:0];
				l_wd = b_q;
				dn_d = dn_q + 1'b1;
				i_d  = i_p1;
				if (i_p1 < cnt_q) begin
					state_d = S_CH_RD;
				end else begin
					j_d     = dn_q;
					state_d = S_MRG_RD;
				end
			end
			S_MRG_RD: begin
				if ((j_q >= CNTW'(2)) && (up_q < CNTW'(MAX_POINTS))) begin
					l_re    = 1'b1;
					l_ra    = j_m1[AW-1:0];
					state_d = S_MRG_WR;
				end else begin
					hn_d    = up_q;
					i_d     = '0;
					found_d = 1'b0;
					best_d  = '0;
					state_d = S_B_EDGE;
				end
			end
			S_MRG_WR: begin
				h_we    = 1'b1;
				h_wa    = up_q[AW-1:0];
				h_wd    = l_rd_q;
				up_d    = up_q + 1'b1;
				j_d     = j_m1;
				state_d = S_MRG_RD;
			end
			S_B_EDGE: begin
				if (i_q < hn_q) begin
					h_re    = 1'b1;
					h_ra    = i_q[AW-1:0];
					state_d = S_B_RB;
				end else begin
					k_d     = '0;
					state_d = S_E_RD;
				end
			end
			S_B_RB: begin
				o_d     = h_rd_q;
				h_re    = 1'b1;
				h_ra    = (i_p1 == hn_q) ? '0 : i_p1[AW-1:0];
				state_d = S_B_LB;
			end
			S_B_LB: begin
				a_d     = h_rd_q;
				state_d = S_B_L1;
			end
			S_B_L1: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				ma = MW'(d_ax);
				mb = MW'(d_ax);
				state_d = S_B_L2;
			end
			S_B_L2: begin
				mac_ctl.en = 1'b1;
				ma = MW'(d_ay);
				mb = MW'(d_ay);
				state_d = S_B_LCHK;
			end
			S_B_LCHK: begin
				// zero-length edges do not count
				if (acc[LW-1:0] == '0) begin
					i_d     = i_p1;
					state_d = S_B_EDGE;
				end else begin
					len2_d  = acc[LW-1:0];
					k_d     = '0;
					cmax_d  = '0;
					state_d = S_B_RK;
				end
			end
			S_B_RK: begin
				h_re    = 1'b1;
				h_ra    = k_q[AW-1:0];
				state_d = S_B_K;
			end
			S_B_K: begin
				b_d     = h_rd_q;
				state_d = S_B_C1;
			end
			S_B_CMAX: begin
				if (cmag > cmax_q) begin
					cmax_d = cmag;
				end
				k_d     = k_p1;
				state_d = (k_p1 < hn_q) ? S_B_RK : S_B_SQ1;
			end
			S_B_SQ1: begin
				// cmax squared, scaled by the fraction bits, in three partial products
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_ctl.sh  = SH_HI;
				ma = MW'({1'b0, cmax_q[CMW-1:H]});
				mb = MW'({1'b0, cmax_q[CMW-1:H]});
				state_d = S_B_SQ2;
			end
			S_B_SQ2: begin
				mac_ctl.en = 1'b1;
				mac_ctl.sh = SH_MID;
				ma = MW'({1'b0, cmax_q[CMW-1:H]});
				mb = MW'({1'b0, cmax_q[H-1:0]});
				state_d = S_B_SQ3;
			end
			S_B_SQ3: begin
				mac_ctl.en = 1'b1;
				mac_ctl.sh = SH_LO;
				ma = MW'({1'b0, cmax_q[H-1:0]});
				mb = MW'({1'b0, cmax_q[H-1:0]});
				state_d = S_B_ROOT;
			end
			S_B_ROOT: begin
				root_start = 1'b1;
				state_d    = S_B_WAIT;
			end
			S_B_WAIT: begin
				if (root_stat.done) begin
					if (!found_q || (root_val < best_q)) begin
						best_d = root_val;
					end
					found_d = 1'b1;
					i_d     = i_p1;
					state_d = S_B_EDGE;
				end
			end
			S_E_RD: begin
				h_re    = 1'b1;
				h_ra    = k_q[AW-1:0];
				state_d = S_E_WAIT;
			end
			S_E_WAIT: begin
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					ovtx_d  = h_rd_q;
					olast_d = (k_p1 == hn_q);
					obr_d   = ((k_p1 == hn_q) && found_q) ? best_q : '0;
					odeg_d  = (k_p1 == hn_q) && !found_q;
					k_d     = k_p1;
					if (k_p1 == hn_q) begin
						cnt_d   = '0;
						state_d = S_LOAD;
					end else begin
						state_d = S_E_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign out_valid   = ov_q;
	assign hull_x      = ovtx_q[VW-1:CW];
	assign hull_y      = ovtx_q[CW-1:0];
	assign last_vertex = olast_q;
	assign min_breadth = obr_q;
	assign degenerate  = odeg_q;

	a_mid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_vertex |-> (min_breadth == '0) && !degenerate)
		else $error("breadth fields set on a vertex that is not the last");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> min_breadth == '0)
		else $error("degenerate result with nonzero breadth");

	a_root_owner: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.busy |-> state_q == S_B_WAIT)
		else $error("root unit busy outside the breadth wait");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MRG_WR |-> up_q < CNTW'(MAX_POINTS))
		else $error("hull store overrun during merge");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the convex hull / minimum breadth block.
// ----------------------------------------------------------------------------
// Point sets go in one transaction at a time. When the final point of a set
// is accepted, the bench works out the hull in clockwise order and the
// minimum breadth on its own. Each vertex that comes out is checked against
// the oldest expected vertex. Directed sets come first. They cover single
// points, extreme coordinates, collinear and coincident points, and an
// overfull store. Random sets follow, under changing idle patterns on both
// sides, and with a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import chmb_pkg::*;

	localparam int NPTS  = MAX_POINTS_DEF;
	localparam int CBITS = COORD_BITS_DEF;
	localparam int FBITS = FRAC_BITS_DEF;
	localparam longint CMIN = -(64'sd1 <<< (CBITS - 1));
	localparam longint CMAX = (64'sd1 <<< (CBITS - 1)) - 1;
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		longint x;
		longint y;
	} point_t;

	typedef struct {
		logic signed [CBITS-1:0]   x;
		logic signed [CBITS-1:0]   y;
		logic                      fin;
		logic [BREADTH_BITS-1:0]   breadth;
		logic                      degen;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CBITS-1:0] point_x = '0;
	logic signed [CBITS-1:0] point_y = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CBITS-1:0] hull_x;
	logic signed [CBITS-1:0] hull_y;
	logic last_vertex;
	logic [BREADTH_BITS-1:0] min_breadth;
	logic degenerate;

	point_t  set_points[$];
	vertex_t hull_expected[$];
	int      mismatches = 0;
	int      snd_idle = 0;
	int      rcv_idle = 0;
	int      hold_req = 0;
	int      hold_served = 0;
	int      hold_left = 0;
	int      quiet_cycles = 0;

	convex_hull_min_breadth DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.hull_x(hull_x), .hull_y(hull_y), .last_vertex(last_vertex),
		.min_breadth(min_breadth), .degenerate(degenerate)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint turn_of(point_t o, point_t a, point_t b);
		return (a.x - o.x) * (b.y - o.y) - (a.y - o.y) * (b.x - o.x);
	endfunction

	function automatic bit precedes(point_t a, point_t b);
		return a.x < b.x || (a.x == b.x && a.y < b.y);
	endfunction

	// floor(c * 2^FBITS / sqrt(len2)), saturated
	function automatic longint unsigned scaled_distance(longint unsigned c,
			longint unsigned len2);
		bit [127:0] r;
		bit [127:0] p;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		r = (128'(c) * 128'(c)) << (2 * FBITS);
		lo = 0;
		hi = (64'd1 << BREADTH_BITS) - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			p = 128'(mid * mid) * 128'(len2);
			if (p <= r)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// builds the hull of the stored set and queues its vertices
	task automatic predict_hull();
		point_t s[$];
		point_t hull[NPTS];
		point_t lower[NPTS];
		point_t v;
		point_t a;
		point_t b;
		vertex_t e;
		int n;
		int up;
		int dn;
		int j;
		longint dx;
		longint dy;
		longint c;
		longint unsigned len2;
		longint unsigned cmax;
		longint unsigned d;
		longint unsigned best;
		bit found;
		s = set_points;
		n = s.size();
		for (int i = 1; i < n; i++) begin
			v = s[i];
			j = i;
			while (j > 0 && precedes(v, s[j-1])) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = v;
		end
		up = 0;
		dn = 0;
		if (n <= 3) begin
			for (int i = 0; i < n; i++)
				hull[i] = s[i];
			up = n;
		end else begin
			for (int i = 0; i < n; i++) begin
				while (up >= 2 && turn_of(hull[up-2], hull[up-1], s[i]) >= 0)
					up--;
				hull[up++] = s[i];
				while (dn >= 2 && turn_of(lower[dn-2], lower[dn-1], s[i]) <= 0)
					dn--;
				lower[dn++] = s[i];
			end
			for (j = dn - 1; j >= 2 && up < NPTS; j--)
				hull[up++] = lower[j-1];
		end
		best = 0;
		found = 1'b0;
		for (int i = 0; i < up; i++) begin
			a = hull[i];
			b = hull[(i + 1) % up];
			dx = b.x - a.x;
			dy = b.y - a.y;
			len2 = dx * dx + dy * dy;
			if (len2 != 0) begin
				cmax = 0;
				for (int k = 0; k < up; k++) begin
					c = turn_of(a, b, hull[k]);
					if (c < 0)
						c = -c;
					if (c > cmax)
						cmax = c;
				end
				d = scaled_distance(cmax, len2);
				if (!found || d < best)
					best = d;
				found = 1'b1;
			end
		end
		for (int k = 0; k < up; k++) begin
			e.x = hull[k].x[CBITS-1:0];
			e.y = hull[k].y[CBITS-1:0];
			e.fin = (k == up - 1);
			e.breadth = (e.fin && found) ? best[BREADTH_BITS-1:0] : '0;
			e.degen = e.fin && !found;
			hull_expected.insert(hull_expected.size(), e);
		end
		set_points.delete();
	endtask

	task automatic send_point(longint x, longint y, bit fin);
		point_t p;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x[CBITS-1:0];
		point_y <= y[CBITS-1:0];
		last_point <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		p.x = x;
		p.y = y;
		if (set_points.size() < NPTS)
			set_points.insert(set_points.size(), p);
		if (fin)
			predict_hull();
	endtask

	function automatic longint rand_coord(int mode);
		case (mode)
			0: return longint'($urandom_range(2 * CMAX + 1)) + CMIN;
			1: return longint'($urandom_range(16)) - 8;
			2: return $urandom_range(1) ? CMAX - $urandom_range(3) : CMIN + $urandom_range(3);
			default: return longint'($urandom_range(200)) - 100;
		endcase
	endfunction

	// mode 0 full range, 1 small box, 2 near extremes, 3 line, 4 all equal
	task automatic send_set(int n, int mode);
		longint x0;
		longint y0;
		longint sx;
		longint sy;
		longint t;
		x0 = rand_coord(1);
		y0 = rand_coord(1);
		sx = longint'($urandom_range(6)) - 3;
		sy = longint'($urandom_range(6)) - 3;
		for (int i = 0; i < n; i++) begin
			if (mode == 3) begin
				t = longint'($urandom_range(40)) - 20;
				send_point(x0 + sx * t, y0 + sy * t, i == n - 1);
			end else if (mode == 4)
				send_point(x0, y0, i == n - 1);
			else
				send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (hull_expected.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_point(CMIN, CMAX, 1'b1);
		send_point(CMAX, CMIN, 1'b0);
		send_point(CMIN, CMAX, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(5, 5, 1'b0);
		send_point(-5, -5, 1'b1);
		// square at the corners of the coordinate range
		send_point(CMIN, CMIN, 1'b0);
		send_point(CMAX, CMAX, 1'b0);
		send_point(CMIN, CMAX, 1'b0);
		send_point(CMAX, CMIN, 1'b1);
		// coincident points: no edge of nonzero length
		send_set(5, 4);
		// collinear points with a duplicate
		send_point(0, 0, 1'b0);
		send_point(1, 1, 1'b0);
		send_point(1, 1, 1'b0);
		send_point(2, 2, 1'b0);
		send_point(3, 3, 1'b1);
	endtask

	// more points than the store holds, the ones beyond NPTS are dropped
	task automatic test_store_full();
		send_set(NPTS + 6, 1);
		drain();
	endtask

	task automatic test_random(int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 4) : $urandom_range(10, 1);
			send_set(n, $urandom_range(4));
			sent += n;
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		send_set(6, 0);
		send_set(4, 1);
		send_set(3, 0);
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_served) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			if (hull_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex x=%0d y=%0d", hull_x, hull_y);
			end else begin
				e = hull_expected.pop_front();
				if (hull_x !== e.x || hull_y !== e.y || last_vertex !== e.fin ||
						min_breadth !== e.breadth || degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("vertex mismatch: exp x=%0d y=%0d last=%0d b=%0d dg=%0d",
							e.x, e.y, e.fin, e.breadth, e.degen);
						$display("  got x=%0d y=%0d last=%0d b=%0d dg=%0d",
							hull_x, hull_y, last_vertex, min_breadth, degenerate);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 19;
		rcv_idle = 88;
		test_directed();
		test_store_full();
		test_random(40);
		snd_idle = 88;
		rcv_idle = 19;
		test_random(40);
		snd_idle = 0;
		rcv_idle = 0;
		test_backpressure();
		test_random(40);
		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && hull_expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
